[src/rth_pkg.sv]
// Shared widths, constants and types for the RGB to HSV converter.
`default_nettype none
package rth_pkg;
  localparam int COMP_W = 16;
  localparam int MAG_W = 19;
  localparam int NUM_W = 2 * COMP_W;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [COMP_W-1:0] HUE_FULL_TURN = 16'd46080;

  typedef struct packed {
    logic              gray;
    logic [COMP_W-1:0] mx;
    logic [COMP_W-1:0] delta;
    logic              hneg;
    logic [MAG_W-1:0]  hmag;
  } rth_class_t;
endpackage
`default_nettype wire

[src/rth_rgb_if.sv]
// Pixel input channel: valid/ready with red, green and blue components.
`default_nettype none
interface rth_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [rth_pkg::COMP_W-1:0] red;
  logic [rth_pkg::COMP_W-1:0] green;
  logic [rth_pkg::COMP_W-1:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

[src/rth_hsv_if.sv]
// Result channel: valid/ready with hue, saturation and brightness.
`default_nettype none
interface rth_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [rth_pkg::COMP_W-1:0] hue;
  logic [rth_pkg::COMP_W-1:0] saturation;
  logic [rth_pkg::COMP_W-1:0] brightness;

  modport source(output valid, output hue, output saturation, output brightness, input ready);
  modport sink(input valid, input hue, input saturation, input brightness, output ready);
endinterface
`default_nettype wire

[src/rth_front.sv]
// Front stage: max/min search, sector selection and signed hue numerator.
`default_nettype none
module rth_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rth_pkg::COMP_W-1:0] red,
  input  wire logic [rth_pkg::COMP_W-1:0] green,
  input  wire logic [rth_pkg::COMP_W-1:0] blue,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rth_pkg::rth_class_t             out_item
);
  localparam int W = rth_pkg::COMP_W;
  localparam int MW = rth_pkg::MAG_W;

  logic                 valid;
  rth_pkg::rth_class_t  item;
  rth_pkg::rth_class_t  item_next;
  logic [W-1:0]         mx;
  logic [W-1:0]         mn;
  logic [W-1:0]         delta;
  logic signed [MW:0]   diff;
  logic signed [MW:0]   offset;
  logic signed [MW:0]   num;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    if (red >= mx) begin
      diff   = $signed({{(MW+1-W){1'b0}}, green}) - $signed({{(MW+1-W){1'b0}}, blue});
      offset = '0;
    end else if (green >= mx) begin
      diff   = $signed({{(MW+1-W){1'b0}}, blue}) - $signed({{(MW+1-W){1'b0}}, red});
      offset = $signed({{(MW-W){1'b0}}, delta, 1'b0});
    end else begin
      diff   = $signed({{(MW+1-W){1'b0}}, red}) - $signed({{(MW+1-W){1'b0}}, green});
      offset = $signed({{(MW-W-1){1'b0}}, delta, 2'b00});
    end
    num = offset + diff;

    item_next.gray  = (delta == '0);
    item_next.mx    = mx;
    item_next.delta = delta;
    item_next.hneg  = num[MW];
    item_next.hmag  = num[MW] ? MW'(-num) : num[MW-1:0];
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end
endmodule
`default_nettype wire

[src/rth_queue.sv]
// Small FIFO between the classify stage and the divide pipeline.
`default_nettype none
module rth_queue #(
  parameter int Depth = rth_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rth_pkg::rth_class_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rth_pkg::rth_class_t       out_item
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rth_pkg::rth_class_t mem [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                push;
  logic                pop;

  assign in_ready  = (count != CntW'(Depth));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end
endmodule
`default_nettype wire

[src/rth_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, quotient known to fit 16 bits.
`default_nettype none
module rth_divider (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [rth_pkg::NUM_W-1:0]  dividend,
  input  wire logic [rth_pkg::COMP_W-1:0] divisor,
  output logic [rth_pkg::COMP_W-1:0]      quotient,
  output logic [rth_pkg::COMP_W-1:0]      remainder
);
  localparam int W = rth_pkg::COMP_W;

  logic [W-1:0] rem_r [W];
  logic [W-1:0] lo_r  [W];
  logic [W-1:0] quo_r [W];
  logic [W-1:0] div_r [W];

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W-1:0] rem_in;
    logic [W-1:0] lo_in;
    logic [W-1:0] quo_in;
    logic [W-1:0] div_in;
    logic [W:0]   trial;
    logic         fits;

    if (i == 0) begin : g_first
      assign rem_in = dividend[2*W-1:W];
      assign lo_in  = dividend[W-1:0];
      assign quo_in = '0;
      assign div_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign lo_in  = lo_r[i-1];
      assign quo_in = quo_r[i-1];
      assign div_in = div_r[i-1];
    end

    assign trial = {rem_in, lo_in[W-1]};
    assign fits  = (trial >= {1'b0, div_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= fits ? W'(trial - {1'b0, div_in}) : trial[W-1:0];
        lo_r[i]  <= {lo_in[W-2:0], 1'b0};
        quo_r[i] <= {quo_in[W-2:0], fits};
        div_r[i] <= div_in;
      end
    end
  end

  assign quotient  = quo_r[W-1];
  assign remainder = rem_r[W-1];
endmodule
`default_nettype wire

[src/rth_back.sv]
// Back end: dividend prep, saturation and hue dividers, hue wrap and output register.
`default_nettype none
module rth_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire rth_pkg::rth_class_t        in_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rth_pkg::COMP_W-1:0]      hue,
  output logic [rth_pkg::COMP_W-1:0]      saturation,
  output logic [rth_pkg::COMP_W-1:0]      brightness
);
  localparam int W = rth_pkg::COMP_W;
  localparam int NW = rth_pkg::NUM_W;
  localparam int Stages = rth_pkg::COMP_W;

  logic          en;
  logic          p_valid;
  logic          p_gray;
  logic          p_hneg;
  logic [W-1:0]  p_mx;
  logic [W-1:0]  p_delta;
  logic [NW-1:0] p_sat_num;
  logic [NW-1:0] p_hue_num;

  logic          v_line    [Stages];
  logic          gray_line [Stages];
  logic          hneg_line [Stages];
  logic [W-1:0]  mx_line   [Stages];

  logic [W-1:0]  sat_q;
  logic [W-1:0]  sat_r;
  logic [W-1:0]  hue_q;
  logic [W-1:0]  hue_r;
  logic [W-1:0]  hue_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      for (int i = 0; i < Stages; i++) begin
        v_line[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      v_line[0] <= p_valid;
      for (int i = 1; i < Stages; i++) begin
        v_line[i] <= v_line[i-1];
      end
      out_valid <= v_line[Stages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_gray    <= in_item.gray;
      p_hneg    <= in_item.hneg;
      p_mx      <= in_item.mx;
      p_delta   <= in_item.delta;
      p_sat_num <= {in_item.delta, {W{1'b0}}} - NW'(in_item.delta);
      p_hue_num <= (NW'(in_item.hmag) << 13) - (NW'(in_item.hmag) << 9);
      gray_line[0] <= p_gray;
      hneg_line[0] <= p_hneg;
      mx_line[0]   <= p_mx;
      for (int i = 1; i < Stages; i++) begin
        gray_line[i] <= gray_line[i-1];
        hneg_line[i] <= hneg_line[i-1];
        mx_line[i]   <= mx_line[i-1];
      end
      hue        <= gray_line[Stages-1] ? '0 : hue_next;
      saturation <= gray_line[Stages-1] ? '0 : sat_q;
      brightness <= mx_line[Stages-1];
    end
  end

  rth_divider u_sat_div (
    .clk       (clk),
    .en        (en),
    .dividend  (p_sat_num),
    .divisor   (p_mx),
    .quotient  (sat_q),
    .remainder (sat_r)
  );

  rth_divider u_hue_div (
    .clk       (clk),
    .en        (en),
    .dividend  (p_hue_num),
    .divisor   (p_delta),
    .quotient  (hue_q),
    .remainder (hue_r)
  );

  always_comb begin
    if (hneg_line[Stages-1]) begin
      hue_next = rth_pkg::HUE_FULL_TURN - hue_q - W'(hue_r != '0);
    end else begin
      hue_next = hue_q;
    end
  end
endmodule
`default_nettype wire

[src/rgb_to_hsv_converter_top.sv]
// RGB to HSV converter top level.
// Path: front register, queue entry, dividend prep register, divider stages, output register.
// Throughput: one pixel per cycle unless output stalls, via 16-stage sat and hue dividers.
// A 4-entry queue decouples the classify stage from the divide pipeline.
// Reset: synchronous, clears all valid flags and queue pointers; data registers are not reset.
`default_nettype none
module rgb_to_hsv_converter_top #(
  parameter int QueueDepth = rth_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rth_rgb_if.sink    rgb,
  rth_hsv_if.source  hsv
);
  logic                f_valid;
  logic                f_ready;
  rth_pkg::rth_class_t f_item;
  logic                q_valid;
  logic                q_ready;
  rth_pkg::rth_class_t q_item;

  rth_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rgb.valid),
    .in_ready  (rgb.ready),
    .red       (rgb.red),
    .green     (rgb.green),
    .blue      (rgb.blue),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  rth_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  rth_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (hsv.valid),
    .out_ready  (hsv.ready),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness)
  );
endmodule
`default_nettype wire
